>>> sv/asb_pkg.sv
// shared types and constants for the one-axis broad-phase table
`default_nettype none
package asb_pkg;

    localparam int unsigned ID_W     = 6;
    localparam int unsigned POS_W    = 24;
    localparam int unsigned RAD_W    = 16;
    localparam int unsigned WIN_W    = 26;
    localparam int unsigned MASK_W   = 64;
    localparam int unsigned GROUP_SZ = 8;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_DUP    = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_APPLY = 5'b00010,
        S_RED1  = 5'b00100,
        S_RED2  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic    load;
        logic    set_status;
        t_status status;
        logic    do_write;
        logic    do_clear;
        logic    do_query;
        logic    red1;
        logic    red2;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  id_valid;
        logic  id_present;
    } t_stat;

endpackage
`default_nettype wire

>>> sv/asb_dpath.sv
// datapath: slot cells, query window compare, radius max tree, result registers
`default_nettype none
module asb_dpath
    import asb_pkg::*;
#(
    parameter int unsigned MAX_BODIES = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    input  wire logic [1:0]         i_kind,
    input  wire logic [ID_W-1:0]    i_body_id,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic [RAD_W-1:0]   i_radius,
    input  wire logic [POS_W-1:0]   i_query_a,
    input  wire logic [POS_W-1:0]   i_query_b,
    output logic [MASK_W-1:0]       o_candidate_mask,
    output logic [1:0]              o_status,
    output logic [RAD_W-1:0]        o_current_search_radius
);

    localparam int unsigned IDX_W  = $clog2(MAX_BODIES);
    localparam int unsigned NGROUP = (MAX_BODIES + GROUP_SZ - 1) / GROUP_SZ;

    t_kind                   r_kind;
    logic [ID_W-1:0]         r_id;
    logic signed [POS_W-1:0] r_pos;
    logic [RAD_W-1:0]        r_rad;
    logic signed [POS_W-1:0] r_qa;
    logic signed [POS_W-1:0] r_qb;

    logic [MAX_BODIES-1:0]   r_present;
    logic signed [POS_W-1:0] r_pos_mem [MAX_BODIES];
    logic [RAD_W-1:0]        r_rad_mem [MAX_BODIES];

    logic [RAD_W-1:0]        r_group_max [NGROUP];
    logic [RAD_W-1:0]        r_search_radius;
    logic [MASK_W-1:0]       r_mask;
    t_status                 r_status;
    logic [MASK_W-1:0]       r_out_mask;
    t_status                 r_out_status;
    logic [RAD_W-1:0]        r_out_radius;

    logic [IDX_W-1:0]        w_idx;
    logic signed [WIN_W-1:0] w_lo;
    logic signed [WIN_W-1:0] w_hi;
    logic [MASK_W-1:0]       w_mask;
    logic [RAD_W-1:0]        w_eff [NGROUP*GROUP_SZ];
    logic [RAD_W-1:0]        n_group_max [NGROUP];
    logic [RAD_W-1:0]        n_search_radius;

    assign w_idx             = r_id[IDX_W-1:0];
    assign o_stat.kind       = r_kind;
    assign o_stat.id_valid   = ({1'b0, r_id} < (ID_W+1)'(MAX_BODIES));
    assign o_stat.id_present = r_present[w_idx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_kind'(i_kind);
            r_id   <= i_body_id;
            r_pos  <= i_position;
            r_rad  <= i_radius;
            r_qa   <= i_query_a;
            r_qb   <= i_query_b;
        end
    end

    // slot cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (i_cmd.do_write) begin
            r_present[w_idx] <= 1'b1;
        end else if (i_cmd.do_clear) begin
            r_present[w_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write) begin
            r_pos_mem[w_idx] <= r_pos;
            r_rad_mem[w_idx] <= r_rad;
        end
    end

    // query window
    always_comb begin
        logic signed [POS_W-1:0] a_min;
        logic signed [POS_W-1:0] b_max;
        if (r_qa > r_qb) begin
            a_min = r_qb;
            b_max = r_qa;
        end else begin
            a_min = r_qa;
            b_max = r_qb;
        end
        w_lo = WIN_W'(a_min) - $signed({{(WIN_W-RAD_W){1'b0}}, r_search_radius});
        w_hi = WIN_W'(b_max) + $signed({{(WIN_W-RAD_W){1'b0}}, r_search_radius});
    end

    always_comb begin
        logic signed [WIN_W-1:0] p;
        w_mask = '0;
        for (int i = 0; i < MAX_BODIES; i++) begin
            p = WIN_W'(r_pos_mem[i]);
            w_mask[i] = r_present[i] && (p >= w_lo) && (p <= w_hi);
        end
    end

    // radius max tree
    for (genvar e = 0; e < NGROUP*GROUP_SZ; e++) begin : g_eff
        if (e < MAX_BODIES) begin : g_cell
            assign w_eff[e] = r_present[e] ? r_rad_mem[e] : '0;
        end else begin : g_pad
            assign w_eff[e] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            n_group_max[g] = '0;
            for (int k = 0; k < GROUP_SZ; k++) begin
                if (w_eff[g*GROUP_SZ+k] > n_group_max[g]) begin
                    n_group_max[g] = w_eff[g*GROUP_SZ+k];
                end
            end
        end
    end

    always_comb begin
        n_search_radius = '0;
        for (int g = 0; g < NGROUP; g++) begin
            if (r_group_max[g] > n_search_radius) begin
                n_search_radius = r_group_max[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.red1) begin
            for (int g = 0; g < NGROUP; g++) begin
                r_group_max[g] <= n_group_max[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_radius <= '0;
        end else if (i_cmd.red2) begin
            r_search_radius <= n_search_radius;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
            r_mask   <= i_cmd.do_query ? w_mask : '0;
        end
        if (i_cmd.out_load) begin
            r_out_mask   <= r_mask;
            r_out_status <= r_status;
            r_out_radius <= r_search_radius;
        end
    end

    assign o_candidate_mask        = r_out_mask;
    assign o_status                = r_out_status;
    assign o_current_search_radius = r_out_radius;

    a_query_keeps_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_query |=> $stable(r_present))
        else $error("query changed the table");

    a_write_sets_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_write |=> r_present[$past(w_idx)])
        else $error("written slot not present");

    a_empty_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.red2) && (r_present == '0) |-> (r_search_radius == '0))
        else $error("empty table with nonzero search radius");

endmodule
`default_nettype wire

>>> sv/asb_ctrl.sv
// controller: sequences accept, table update, radius reduction and result handoff
`default_nettype none
module asb_ctrl
    import asb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_change;

    always_comb begin
        o_cmd            = '0;
        o_cmd.status     = ST_OK;
        w_change         = 1'b0;
        n_state          = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.set_status = 1'b1;
                if (i_stat.kind == KIND_QUERY) begin
                    o_cmd.do_query = 1'b1;
                end else if (!i_stat.id_valid) begin
                    o_cmd.status = ST_ABSENT;
                end else if (i_stat.kind == KIND_INSERT) begin
                    if (i_stat.id_present) begin
                        o_cmd.status = ST_DUP;
                    end else begin
                        o_cmd.do_write = 1'b1;
                        w_change       = 1'b1;
                    end
                end else if (!i_stat.id_present) begin
                    o_cmd.status = ST_ABSENT;
                end else if (i_stat.kind == KIND_UPDATE) begin
                    o_cmd.do_write = 1'b1;
                    w_change       = 1'b1;
                end else begin
                    o_cmd.do_clear = 1'b1;
                    w_change       = 1'b1;
                end
                n_state = w_change ? S_RED1 : S_DONE;
            end
            S_RED1: begin
                o_cmd.red1 = 1'b1;
                n_state    = S_RED2;
            end
            S_RED2: begin
                o_cmd.red2 = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

    a_tree_two_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.do_write || o_cmd.do_clear) |=> o_cmd.red1 ##1 o_cmd.red2)
        else $error("radius reduction skipped after table change");

endmodule
`default_nettype wire

>>> sv/axis_sweep_broadphase_top.sv
// top level of the one-axis broad-phase table
// steps: insert, update or remove that changes the table runs accept, apply, both reduction
// steps and result register load; a query or flagged item skips the reduction steps
// a new transaction is taken after the last one's result load; the two-stage registered
// max tree adds the reduction steps to a table change; input is taken while a result waits
// reset: synchronous active low; clears slot presence, search radius and control, no sweep
`default_nettype none
module axis_sweep_broadphase_top
    import asb_pkg::*;
#(
    parameter int unsigned MAX_BODIES = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_kind,
    input  wire logic [ID_W-1:0]    i_body_id,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic [RAD_W-1:0]   i_radius,
    input  wire logic [POS_W-1:0]   i_query_a,
    input  wire logic [POS_W-1:0]   i_query_b,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [MASK_W-1:0]       o_candidate_mask,
    output logic [1:0]              o_status,
    output logic [RAD_W-1:0]        o_current_search_radius
);

    t_cmd  w_cmd;
    t_stat w_stat;

    asb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    asb_dpath #(
        .MAX_BODIES (MAX_BODIES)
    ) u_dpath (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (w_cmd),
        .o_stat                  (w_stat),
        .i_kind                  (i_kind),
        .i_body_id               (i_body_id),
        .i_position              (i_position),
        .i_radius                (i_radius),
        .i_query_a               (i_query_a),
        .i_query_b               (i_query_b),
        .o_candidate_mask        (o_candidate_mask),
        .o_status                (o_status),
        .o_current_search_radius (o_current_search_radius)
    );

endmodule
`default_nettype wire

>>> test/axis_sweep_broadphase_top_tb.sv
// testbench for axis_sweep_broadphase_top: directed and random table operations
module axis_sweep_broadphase_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import asb_pkg::*;

    localparam int NUM_SLOTS = 64;
    localparam int N_RANDOM  = 550;

    typedef struct {
        t_kind            kind;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] pos;
        logic [RAD_W-1:0] rad;
        logic [POS_W-1:0] qa;
        logic [POS_W-1:0] qb;
    } t_body_op;

    typedef struct {
        logic [MASK_W-1:0] mask;
        t_status           status;
        logic [RAD_W-1:0]  search_rad;
    } t_table_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_kind;
    logic [ID_W-1:0]   i_body_id;
    logic [POS_W-1:0]  i_position;
    logic [RAD_W-1:0]  i_radius;
    logic [POS_W-1:0]  i_query_a;
    logic [POS_W-1:0]  i_query_b;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [MASK_W-1:0] o_candidate_mask;
    logic [1:0]        o_status;
    logic [RAD_W-1:0]  o_current_search_radius;

    t_body_op      pending_ops[$];
    t_table_result expected_results[$];
    t_body_op      cur_op;
    t_table_result exp_res;

    bit               tbl_present [NUM_SLOTS];
    logic [POS_W-1:0] tbl_pos     [NUM_SLOTS];
    logic [RAD_W-1:0] tbl_rad     [NUM_SLOTS];
    logic [RAD_W-1:0] tbl_search_rad;
    bit               gen_present [NUM_SLOTS];

    bit in_fire;
    bit in_burst;
    bit out_burst;
    int in_gap;
    int out_stall;
    int err_cnt;

    axis_sweep_broadphase_top #(
        .MAX_BODIES(NUM_SLOTS)
    ) u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_kind                 (i_kind),
        .i_body_id              (i_body_id),
        .i_position             (i_position),
        .i_radius               (i_radius),
        .i_query_a              (i_query_a),
        .i_query_b              (i_query_b),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_candidate_mask       (o_candidate_mask),
        .o_status               (o_status),
        .o_current_search_radius(o_current_search_radius)
    );

    always #6 i_clk = ~i_clk;

    function automatic void recompute_search_rad();
        tbl_search_rad = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_present[i] && tbl_rad[i] > tbl_search_rad)
                tbl_search_rad = tbl_rad[i];
        end
    endfunction

    function automatic t_table_result apply_table_op(input t_body_op op);
        t_table_result res;
        int a, b, lo, hi, p;
        res.mask   = '0;
        res.status = ST_OK;
        case (op.kind)
            KIND_QUERY: begin
                a = $signed(op.qa);
                b = $signed(op.qb);
                if (a > b) begin
                    p = a;
                    a = b;
                    b = p;
                end
                lo = a - int'(tbl_search_rad);
                hi = b + int'(tbl_search_rad);
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    p = $signed(tbl_pos[i]);
                    if (tbl_present[i] && p >= lo && p <= hi)
                        res.mask[i] = 1'b1;
                end
            end
            KIND_INSERT: begin
                if (tbl_present[op.id]) begin
                    res.status = ST_DUP;
                end else begin
                    tbl_present[op.id] = 1'b1;
                    tbl_pos[op.id]     = op.pos;
                    tbl_rad[op.id]     = op.rad;
                    recompute_search_rad();
                end
            end
            KIND_UPDATE: begin
                if (!tbl_present[op.id]) begin
                    res.status = ST_ABSENT;
                end else begin
                    tbl_pos[op.id] = op.pos;
                    tbl_rad[op.id] = op.rad;
                    recompute_search_rad();
                end
            end
            default: begin
                if (!tbl_present[op.id]) begin
                    res.status = ST_ABSENT;
                end else begin
                    tbl_present[op.id] = 1'b0;
                    tbl_pos[op.id]     = '0;
                    tbl_rad[op.id]     = '0;
                    recompute_search_rad();
                end
            end
        endcase
        res.search_rad = tbl_search_rad;
        return res;
    endfunction

    task automatic add_op(input t_kind k, input int id, input int pos, input int rad,
                          input int qa, input int qb);
        t_body_op op;
        op.kind = k;
        op.id   = id[ID_W-1:0];
        op.pos  = pos[POS_W-1:0];
        op.rad  = rad[RAD_W-1:0];
        op.qa   = qa[POS_W-1:0];
        op.qb   = qb[POS_W-1:0];
        pending_ops = {pending_ops, op};
        if (k == KIND_INSERT)
            gen_present[op.id] = 1'b1;
        else if (k == KIND_REMOVE)
            gen_present[op.id] = 1'b0;
    endtask

    function automatic int pick_slot(input bit want_present);
        int hits;
        int id;
        hits = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (gen_present[i] == want_present)
                hits++;
        id = $urandom_range(0, NUM_SLOTS - 1);
        if (hits != 0) begin
            while (gen_present[id] != want_present)
                id = $urandom_range(0, NUM_SLOTS - 1);
        end
        return id;
    endfunction

    function automatic int rand_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return int'($urandom_range(0, 8191)) - 4096;
        else if (r < 90)
            return $urandom;
        else
            return ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
    endfunction

    function automatic int rand_rad();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return $urandom_range(0, 1023);
        else if (r < 97)
            return $urandom_range(0, 65535);
        else
            return ($urandom_range(0, 1) != 0) ? 65535 : 0;
    endfunction

    function automatic int idle_len(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // result check first, then prediction of the transaction taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                err_cnt++;
                $display("%0t unexpected result: mask %h status %0d radius %h", $time,
                         o_candidate_mask, o_status, o_current_search_radius);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_candidate_mask !== exp_res.mask) begin
                    err_cnt++;
                    $display("%0t candidate_mask mismatch: expected %h actual %h", $time,
                             exp_res.mask, o_candidate_mask);
                end
                if (o_status !== exp_res.status) begin
                    err_cnt++;
                    $display("%0t status mismatch: expected %0d actual %0d", $time,
                             exp_res.status, o_status);
                end
                if (o_current_search_radius !== exp_res.search_rad) begin
                    err_cnt++;
                    $display("%0t search radius mismatch: expected %h actual %h", $time,
                             exp_res.search_rad, o_current_search_radius);
                end
            end
        end
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        if (in_fire)
            expected_results = {expected_results, apply_table_op(cur_op)};
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                in_gap = idle_len(in_burst);
                if ($urandom_range(0, 49) == 0)
                    in_burst = !in_burst;
            end
            if (!i_in_valid || in_fire) begin
                if (in_gap == 0 && pending_ops.size() != 0) begin
                    cur_op = pending_ops.pop_front();
                    i_kind     <= cur_op.kind;
                    i_body_id  <= cur_op.id;
                    i_position <= cur_op.pos;
                    i_radius   <= cur_op.rad;
                    i_query_a  <= cur_op.qa;
                    i_query_b  <= cur_op.qb;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                    if (in_gap > 0)
                        in_gap--;
                end
            end
            if (out_stall > 0) begin
                i_out_ready <= 1'b0;
                out_stall--;
            end else begin
                i_out_ready <= 1'b1;
                out_stall = idle_len(out_burst);
                if ($urandom_range(0, 49) == 0)
                    out_burst = !out_burst;
            end
        end
    end

    initial begin
        int sel;
        int qa;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_kind      = KIND_INSERT;
        i_body_id   = '0;
        i_position  = '0;
        i_radius    = '0;
        i_query_a   = '0;
        i_query_b   = '0;
        in_fire     = 1'b0;
        in_burst    = 1'b0;
        out_burst   = 1'b0;
        in_gap      = 0;
        out_stall   = 0;
        err_cnt     = 0;
        tbl_search_rad = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            tbl_present[i] = 1'b0;

        add_op(KIND_QUERY, 0, 0, 0, -5, 5);
        add_op(KIND_REMOVE, 5, 0, 0, 0, 0);
        add_op(KIND_UPDATE, 63, 1000, 20, 0, 0);
        add_op(KIND_INSERT, 0, -8388608, 0, 0, 0);
        add_op(KIND_INSERT, 63, 8388607, 65535, 0, 0);
        add_op(KIND_INSERT, 0, 17, 3, 0, 0);
        add_op(KIND_QUERY, 0, 0, 0, 8388607, -8388608);
        add_op(KIND_QUERY, 0, 0, 0, 0, 0);
        add_op(KIND_UPDATE, 63, 100, 256, 0, 0);
        add_op(KIND_INSERT, 1, 356, 10, 0, 0);
        add_op(KIND_INSERT, 2, -356, 5, 0, 0);
        add_op(KIND_QUERY, 0, 0, 0, 100, 0);
        add_op(KIND_QUERY, 0, 0, 0, -100, -100);
        add_op(KIND_QUERY, 0, 0, 0, 101, 101);
        add_op(KIND_REMOVE, 63, 0, 0, 0, 0);
        add_op(KIND_REMOVE, 63, 0, 0, 0, 0);
        add_op(KIND_QUERY, 0, 0, 0, -8388608, 8388607);
        add_op(KIND_UPDATE, 0, 8388607, 65535, 0, 0);
        add_op(KIND_QUERY, 0, 0, 0, -8388608, -8388608);
        add_op(KIND_QUERY, 0, 0, 0, 8388607, 8388607);
        add_op(KIND_REMOVE, 0, 0, 0, 0, 0);
        add_op(KIND_REMOVE, 1, 0, 0, 0, 0);
        add_op(KIND_REMOVE, 2, 0, 0, 0, 0);
        add_op(KIND_QUERY, 0, 0, 0, 8388607, -8388608);

        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 99);
            if (sel >= 92) begin
                add_op(t_kind'($urandom_range(0, 3)), $urandom_range(0, NUM_SLOTS - 1),
                       $urandom, $urandom, $urandom, $urandom);
            end else if (sel >= 57) begin
                qa = rand_pos();
                add_op(KIND_QUERY, $urandom_range(0, NUM_SLOTS - 1), $urandom, $urandom, qa,
                       ($urandom_range(0, 3) == 0) ? rand_pos()
                                                   : qa + int'($urandom_range(0, 1024)) - 512);
            end else if (sel < 25 || pick_slot(1'b1) < 0) begin
                add_op(KIND_INSERT, pick_slot(1'b0), rand_pos(), rand_rad(), $urandom, $urandom);
            end else if (sel < 43) begin
                add_op(KIND_UPDATE, pick_slot(1'b1), rand_pos(), rand_rad(), $urandom, $urandom);
            end else begin
                add_op(KIND_REMOVE, pick_slot(1'b1), $urandom, $urandom, $urandom, $urandom);
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
